### rtl/stb_pkg.sv
package stb_pkg;

    localparam int NUM_TIMERS = 8;
    localparam int SEL_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 16;
    localparam int TICK_W     = 32;
    localparam int MASK_W     = 8;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_SET   = 2'd1,
        MODE_CHECK = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    // One timer as it travels around the ring.
    typedef struct packed {
        logic [CNT_W-1:0] remaining;
        logic [CNT_W-1:0] reload;
        logic             mark;
    } timer_t;

    // What the head does to the timer passing through it.
    typedef struct packed {
        timer_t entry;
        logic   expire;
        logic   flag;
    } head_res_t;

endpackage

### rtl/software_timer_bank.sv
// Bank of countdown timers sharing one wrapping 32-bit tick counter.
// Input beats arrive on the s_ channel: s_tuser carries the mode (tick, set,
// check and clear, read count) and s_tdata the timer index, timeout value and
// free-running bit. Every input beat yields exactly one output beat on the
// m_ channel holding the fired mask, the expired flag and the tick count.
// The timers sit in a ring of cells that rotates by one place per cycle while
// an item is processed, except while the final step waits on the receiver;
// the cell entry point runs the update for the timer passing through it. A
// full rotation brings each timer through it once, and a new beat is accepted
// only after the walk has ended. The ring length sets the length of the walk.
// The result sits in an output register, so the next beat is accepted while
// a result still waits. If the receiver stalls, the walk holds on its final
// step until the output register frees up, and nothing is lost.
// Reset clears all timers (inactive, zero reload, no expired marks), the tick
// counter and the output valid; no clearing pass is needed.
module software_timer_bank
    import stb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] timer_index, [19:4] timeout_value, [20] free_running, [23:21] zero
    input  logic [23:0] s_tdata,
    // [1:0] mode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] fired_mask, [8] expired_flag, [40:9] tick_count, [47:41] zero
    output logic [47:0] m_tdata
);

    localparam logic [SEL_W-1:0] LAST_STEP = SEL_W'(NUM_TIMERS - 1);

    state_t state_reg, state_next;
    logic [SEL_W-1:0] step_reg, step_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [MASK_W-1:0] fired_reg, fired_next;
    logic flag_reg, flag_next;
    logic m_valid_reg, m_valid_next;
    logic [47:0] m_data_reg, m_data_next;

    // Operation being walked; payload only.
    mode_t            mode_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] tmo_reg;
    logic             free_reg;

    logic accept;
    logic out_free;
    logic shift;
    logic [SEL_W-1:0] cur_id;
    logic hit;

    timer_t    ring_q [NUM_TIMERS];
    head_res_t head_res;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    // The last cell's timer enters the head; its number counts down per step.
    assign cur_id   = LAST_STEP - step_reg;
    assign hit      = (IDX_W'(cur_id) == idx_reg);

    stb_head u_head (
        .entry         (ring_q[NUM_TIMERS-1]),
        .mode          (mode_reg),
        .hit           (hit),
        .timeout_value (tmo_reg),
        .free_running  (free_reg),
        .res           (head_res)
    );

    genvar k;
    generate
        for (k = 0; k < NUM_TIMERS; k++) begin : g_ring
            if (k == 0) begin : g_first
                stb_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .d     (head_res.entry),
                    .q     (ring_q[k])
                );
            end
            else begin : g_rest
                stb_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .d     (ring_q[k-1]),
                    .q     (ring_q[k])
                );
            end
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        tick_next    = tick_reg;
        fired_next   = fired_reg;
        flag_next    = flag_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        shift        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_WALK;
                    step_next  = '0;
                    fired_next = '0;
                    flag_next  = 1'b0;
                    if (mode_t'(s_tuser) == MODE_TICK) begin
                        tick_next = tick_reg + TICK_W'(1);
                    end
                end
            end
            ST_WALK: begin
                if (step_reg != LAST_STEP || out_free) begin
                    shift      = 1'b1;
                    fired_next = fired_reg
                               | (head_res.expire ? (MASK_W'(1) << cur_id) : '0);
                    flag_next  = flag_reg | head_res.flag;
                    step_next  = step_reg + SEL_W'(1);
                    if (step_reg == LAST_STEP) begin
                        state_next   = ST_IDLE;
                        m_valid_next = 1'b1;
                        m_data_next  = {7'd0, tick_reg, flag_next, fired_next};
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            tick_reg    <= '0;
            fired_reg   <= '0;
            flag_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            tick_reg    <= tick_next;
            fired_reg   <= fired_next;
            flag_reg    <= flag_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        m_data_reg <= m_data_next;
        if (accept) begin
            mode_reg <= mode_t'(s_tuser);
            idx_reg  <= s_tdata[3:0];
            tmo_reg  <= s_tdata[19:4];
            free_reg <= s_tdata[20];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

### rtl/stb_cell.sv
module stb_cell
    import stb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   shift,
    input  timer_t d,
    output timer_t q
);

    timer_t entry_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            entry_reg <= '0;
        end
        else if (shift) begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

### rtl/stb_head.sv
module stb_head
    import stb_pkg::*;
(
    input  timer_t           entry,
    input  mode_t            mode,
    input  logic             hit,
    input  logic [CNT_W-1:0] timeout_value,
    input  logic             free_running,
    output head_res_t        res
);

    logic [CNT_W-1:0] dec;

    assign dec = entry.remaining - CNT_W'(1);

    always_comb begin
        res.entry  = entry;
        res.expire = 1'b0;
        res.flag   = 1'b0;
        unique case (mode)
            MODE_TICK: begin
                if (entry.remaining != '0) begin
                    if (dec == '0) begin
                        res.entry.mark      = 1'b1;
                        res.entry.remaining = entry.reload;
                        res.expire          = 1'b1;
                    end
                    else begin
                        res.entry.remaining = dec;
                    end
                end
            end
            MODE_SET: begin
                if (hit) begin
                    res.entry.mark      = 1'b0;
                    res.entry.remaining = timeout_value;
                    res.entry.reload    = free_running ? timeout_value : '0;
                end
            end
            MODE_CHECK: begin
                if (hit) begin
                    res.flag       = entry.mark;
                    res.entry.mark = 1'b0;
                end
            end
            default: begin
                res.entry = entry;
            end
        endcase
    end

endmodule
